>>> src/hlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hlp_pkg
// Shared types, codes, character constants and helper functions of the
// HTTP header line parser.
// ---------------------------------------------------------------------------
package hlp_pkg;

  localparam int LEN_W       = 17;
  localparam int MAX_RESULTS = 3;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = 2;
  localparam int LEVEL_W     = 3;
  localparam int CNT_W       = 2;

  // a request is taken while the result queue has room for a full run
  localparam logic [LEVEL_W-1:0] ACCEPT_LEVEL = LEVEL_W'(FIFO_DEPTH - MAX_RESULTS);

  localparam logic [LEN_W-1:0] LIMIT_RESET = 17'd8192;
  localparam logic [LEN_W-1:0] LEN_MAX     = 17'h1FFFF;

  localparam logic [1:0] CMD_DATA    = 2'd0;
  localparam logic [1:0] CMD_EOS     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_US    = 8'h5F;

  localparam logic [3:0] TYPE_LEN   = 4'd12;
  localparam logic [3:0] LENGTH_LEN = 4'd14;
  localparam logic [3:0] POS_MAX    = 4'd15;
  localparam logic [8*12-1:0] NAME_TYPE   = {"CONTENT", "_TYPE"};
  localparam logic [8*14-1:0] NAME_LENGTH = {"CONTENT", "_LENGTH"};

  typedef enum logic [2:0] {
    KIND_NAME     = 3'd0,
    KIND_NAME_END = 3'd1,
    KIND_VALUE    = 3'd2,
    KIND_HDR_END  = 3'd3,
    KIND_DONE     = 3'd4,
    KIND_ERROR    = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_EARLY_END  = 2'd0,
    ERR_NO_SPACE   = 2'd1,
    ERR_EMPTY_NAME = 2'd2,
    ERR_NO_COLON   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_FIRST = 2'd2
  } esc_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       no_prefix;
    err_t       code;
    logic       last;
  } result_t;

  typedef struct packed {
    result_t [MAX_RESULTS-1:0] item;
    logic [CNT_W-1:0]          count;
  } batch_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               empty;
  } fifo_status_t;

  typedef struct packed {
    phase_t           phase;
    logic [LEN_W-1:0] len;
    logic [7:0]       held_byte;
    logic             held_valid;
    esc_t             esc;
    logic [7:0]       esc_first;
    logic [3:0]       match_pos;
    logic [1:0]       match_flags;
    kind_t            pend_kind;
    err_t             pend_code;
  } line_state_t;

  function automatic line_state_t fresh_line();
    line_state_t s;
    s.phase       = PH_NAME;
    s.len         = '0;
    s.held_byte   = CH_NUL;
    s.held_valid  = 1'b0;
    s.esc         = ESC_NONE;
    s.esc_first   = CH_NUL;
    s.match_pos   = '0;
    s.match_flags = 2'b11;
    s.pend_kind   = KIND_NAME;
    s.pend_code   = ERR_EARLY_END;
    return s;
  endfunction

  function automatic result_t mk_result(kind_t k, logic [7:0] d, logic np, err_t c);
    result_t r;
    r.kind      = k;
    r.data      = d;
    r.no_prefix = np;
    r.code      = c;
    r.last      = 1'b0;
    return r;
  endfunction

  // {digit found, value}
  function automatic logic [4:0] hexval(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") r = {1'b1, 4'(c - "0")};
    else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
    return r;
  endfunction

  // two characters read as a base-16 number, truncated to a byte
  function automatic logic [7:0] decode_pair(logic [7:0] a, logic [7:0] b);
    logic [4:0] va;
    logic [4:0] vb;
    logic [7:0] r;
    va = hexval(a);
    vb = hexval(b);
    r  = 8'd0;
    if (va[4]) begin
      r = vb[4] ? {va[3:0], vb[3:0]} : {4'd0, va[3:0]};
    end else if (a == CH_SP || a == CH_TAB || a == CH_LF || a == CH_VT ||
                 a == CH_FF || a == CH_CR || a == CH_PLUS) begin
      r = vb[4] ? {4'd0, vb[3:0]} : 8'd0;
    end else if (a == CH_DASH) begin
      r = vb[4] ? 8'(8'd0 - {4'd0, vb[3:0]}) : 8'd0;
    end
    return r;
  endfunction

  function automatic logic match_type(logic [3:0] p, logic [7:0] b);
    logic [3:0] i;
    i = 4'(TYPE_LEN - 4'd1 - p);
    return (p < TYPE_LEN) && (NAME_TYPE[i*8 +: 8] == b);
  endfunction

  function automatic logic match_length(logic [3:0] p, logic [7:0] b);
    logic [3:0] i;
    i = 4'(LENGTH_LEN - 4'd1 - p);
    return (p < LENGTH_LEN) && (NAME_LENGTH[i*8 +: 8] == b);
  endfunction

endpackage
`default_nettype wire

>>> src/hlp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hlp_parser
// Line state registers, size limit register and the per-byte parse logic.
// Produces up to three results for each accepted request.
// ---------------------------------------------------------------------------
module hlp_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [hlp_pkg::LEN_W-1:0] cfg_wr_data,
  input  wire logic                      accept,
  input  wire logic [1:0]                cmd,
  input  wire logic [7:0]                in_byte,
  output hlp_pkg::batch_t                batch
);

  hlp_pkg::line_state_t     st;
  hlp_pkg::line_state_t     st_next;
  logic [hlp_pkg::LEN_W-1:0] limit;
  hlp_pkg::batch_t          res;
  logic [hlp_pkg::CNT_W-1:0] n;
  logic                     at_limit;
  logic [7:0]               t;
  logic                     np;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= hlp_pkg::fresh_line();
      limit <= hlp_pkg::LIMIT_RESET;
    end else begin
      if (accept) st <= st_next;
      if (cfg_wr_en) limit <= cfg_wr_data;
    end
  end

  assign at_limit = (limit != '0) && (st.len >= 17'(limit - 17'd1));

  always_comb begin
    st_next = st;
    res     = '0;
    n       = '0;
    t       = in_byte;
    np      = 1'b0;
    if (cmd == hlp_pkg::CMD_RESTART) begin
      st_next = hlp_pkg::fresh_line();
    end else if (cmd == hlp_pkg::CMD_DATA || cmd == hlp_pkg::CMD_EOS) begin
      if (st.phase == hlp_pkg::PH_STOP) begin
        st_next = st;
      end else if (cmd == hlp_pkg::CMD_EOS) begin
        res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_ERROR, 8'd0, 1'b0,
                                         hlp_pkg::ERR_EARLY_END);
        n = n + 2'd1;
        st_next.phase = hlp_pkg::PH_STOP;
      end else if (in_byte != hlp_pkg::CH_CR) begin
        if (in_byte == hlp_pkg::CH_LF || at_limit) begin
          // end of line
          unique case (st.phase)
            hlp_pkg::PH_NAME: begin
              if (st.len == '0) begin
                res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_DONE, 8'd0, 1'b0,
                                                 hlp_pkg::ERR_EARLY_END);
              end else begin
                res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_ERROR, 8'd0, 1'b0,
                                                 hlp_pkg::ERR_NO_SPACE);
              end
              n = n + 2'd1;
              st_next.phase = hlp_pkg::PH_STOP;
            end
            hlp_pkg::PH_VALUE: begin
              // unfinished escape goes out literally
              if (st.esc != hlp_pkg::ESC_NONE) begin
                res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_VALUE, hlp_pkg::CH_PCT,
                                                 1'b0, hlp_pkg::ERR_EARLY_END);
                n = n + 2'd1;
              end
              if (st.esc == hlp_pkg::ESC_FIRST) begin
                res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_VALUE,
                  (st.esc_first == hlp_pkg::CH_PLUS) ? hlp_pkg::CH_SP : st.esc_first,
                  1'b0, hlp_pkg::ERR_EARLY_END);
                n = n + 2'd1;
              end
              res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_HDR_END, 8'd0, 1'b0,
                                               hlp_pkg::ERR_EARLY_END);
              n = n + 2'd1;
              st_next = hlp_pkg::fresh_line();
            end
            hlp_pkg::PH_SKIP: begin
              res.item[n] = hlp_pkg::mk_result(st.pend_kind, 8'd0, 1'b0, st.pend_code);
              n = n + 2'd1;
              if (st.pend_kind == hlp_pkg::KIND_HDR_END) st_next = hlp_pkg::fresh_line();
              else st_next.phase = hlp_pkg::PH_STOP;
            end
            default: st_next = st;
          endcase
        end else begin
          if (st.phase == hlp_pkg::PH_NAME) begin
            if (in_byte == hlp_pkg::CH_NUL) begin
              st_next.pend_kind = (st.len == '0) ? hlp_pkg::KIND_DONE : hlp_pkg::KIND_ERROR;
              st_next.pend_code = (st.len == '0) ? hlp_pkg::ERR_EARLY_END
                                                 : hlp_pkg::ERR_NO_SPACE;
              st_next.phase     = hlp_pkg::PH_SKIP;
            end else if (in_byte == hlp_pkg::CH_SP) begin
              if (!st.held_valid) begin
                st_next.pend_kind = hlp_pkg::KIND_ERROR;
                st_next.pend_code = hlp_pkg::ERR_EMPTY_NAME;
                st_next.phase     = hlp_pkg::PH_SKIP;
              end else if (st.held_byte != hlp_pkg::CH_COLON) begin
                st_next.pend_kind = hlp_pkg::KIND_ERROR;
                st_next.pend_code = hlp_pkg::ERR_NO_COLON;
                st_next.phase     = hlp_pkg::PH_SKIP;
              end else begin
                np = (st.match_flags[0] && st.match_pos == hlp_pkg::TYPE_LEN) ||
                     (st.match_flags[1] && st.match_pos == hlp_pkg::LENGTH_LEN);
                res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_NAME_END, 8'd0, np,
                                                 hlp_pkg::ERR_EARLY_END);
                n = n + 2'd1;
                st_next.held_valid = 1'b0;
                st_next.phase      = hlp_pkg::PH_VALUE;
              end
            end else begin
              // held byte goes out now; the new one waits in case it is the colon
              if (st.held_valid) begin
                if (!hlp_pkg::match_type(st.match_pos, st.held_byte))
                  st_next.match_flags[0] = 1'b0;
                if (!hlp_pkg::match_length(st.match_pos, st.held_byte))
                  st_next.match_flags[1] = 1'b0;
                if (st.match_pos < hlp_pkg::POS_MAX) st_next.match_pos = st.match_pos + 4'd1;
                res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_NAME, st.held_byte, 1'b0,
                                                 hlp_pkg::ERR_EARLY_END);
                n = n + 2'd1;
              end
              if (in_byte >= "a" && in_byte <= "z") t = 8'(in_byte - 8'd32);
              if (t == hlp_pkg::CH_DASH) t = hlp_pkg::CH_US;
              st_next.held_byte  = t;
              st_next.held_valid = 1'b1;
            end
          end else if (st.phase == hlp_pkg::PH_VALUE) begin
            if (in_byte == hlp_pkg::CH_NUL) begin
              if (st.esc != hlp_pkg::ESC_NONE) begin
                res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_VALUE, hlp_pkg::CH_PCT,
                                                 1'b0, hlp_pkg::ERR_EARLY_END);
                n = n + 2'd1;
              end
              if (st.esc == hlp_pkg::ESC_FIRST) begin
                res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_VALUE,
                  (st.esc_first == hlp_pkg::CH_PLUS) ? hlp_pkg::CH_SP : st.esc_first,
                  1'b0, hlp_pkg::ERR_EARLY_END);
                n = n + 2'd1;
              end
              st_next.esc       = hlp_pkg::ESC_NONE;
              st_next.pend_kind = hlp_pkg::KIND_HDR_END;
              st_next.pend_code = hlp_pkg::ERR_EARLY_END;
              st_next.phase     = hlp_pkg::PH_SKIP;
            end else if (st.esc == hlp_pkg::ESC_PCT) begin
              st_next.esc_first = in_byte;
              st_next.esc       = hlp_pkg::ESC_FIRST;
            end else if (st.esc == hlp_pkg::ESC_FIRST) begin
              res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_VALUE,
                hlp_pkg::decode_pair(st.esc_first, in_byte), 1'b0, hlp_pkg::ERR_EARLY_END);
              n = n + 2'd1;
              st_next.esc = hlp_pkg::ESC_NONE;
            end else if (in_byte == hlp_pkg::CH_PCT) begin
              st_next.esc = hlp_pkg::ESC_PCT;
            end else begin
              res.item[n] = hlp_pkg::mk_result(hlp_pkg::KIND_VALUE,
                (in_byte == hlp_pkg::CH_PLUS) ? hlp_pkg::CH_SP : in_byte,
                1'b0, hlp_pkg::ERR_EARLY_END);
              n = n + 2'd1;
            end
          end
          if (st.len != hlp_pkg::LEN_MAX) st_next.len = st.len + 17'd1;
        end
      end
    end
    if (n != '0) res.item[2'(n - 2'd1)].last = 1'b1;
    res.count = n;
  end

  always_comb begin
    batch = res;
    if (!accept) batch.count = '0;
  end

endmodule
`default_nettype wire

>>> src/hlp_result_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hlp_result_fifo
// Four-entry result queue. Takes a run of up to three results at a time
// and hands out one result per cycle while pop is high.
// ---------------------------------------------------------------------------
module hlp_result_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire hlp_pkg::batch_t batch,
  input  wire logic            pop,
  output hlp_pkg::result_t     head,
  output hlp_pkg::fifo_status_t status
);

  hlp_pkg::result_t mem [hlp_pkg::FIFO_DEPTH];
  logic [hlp_pkg::PTR_W-1:0]   wr_ptr;
  logic [hlp_pkg::PTR_W-1:0]   rd_ptr;
  logic [hlp_pkg::LEVEL_W-1:0] level;
  logic [hlp_pkg::LEVEL_W-1:0] level_next;

  assign level_next = 3'(level + 3'(batch.count) - 3'(pop));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= 2'(wr_ptr + batch.count);
      rd_ptr <= 2'(rd_ptr + 2'(pop));
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < hlp_pkg::MAX_RESULTS; i++) begin
      if (2'(i) < batch.count) mem[2'(wr_ptr + 2'(i))] <= batch.item[i];
    end
  end

  assign head         = mem[rd_ptr];
  assign status.level = level;
  assign status.empty = (level == '0);

endmodule
`default_nettype wire

>>> src/http_header_line_parser_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// http_header_line_parser_unit
// HTTP header line parser with name folding and percent decoding of values.
// ---------------------------------------------------------------------------
// One request (a header byte, end of stream or restart) is taken per cycle
// while req_stall is low; its results, up to three, are produced in the same
// cycle and queued in a four-entry result queue that drains one result per
// cycle while rsp_stall is low. A request is taken while the queue holds at
// most one result, so with one result per byte and no result stall the block
// sustains one byte per clock. Results are registered in the queue.
// cfg_wr_data sets the line size limit (reset 8192) and is written only while
// the block is idle; the user is bound to this, the block does not enforce it.
module http_header_line_parser_unit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [hlp_pkg::LEN_W-1:0] cfg_wr_data,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire logic [1:0]                cmd,
  input  wire logic [7:0]                in_byte,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output logic [2:0]                     kind,
  output logic [7:0]                     out_byte,
  output logic                           no_prefix,
  output logic [1:0]                     error_code,
  output logic                           last_of_run
);

  hlp_pkg::batch_t       batch;
  hlp_pkg::result_t      head;
  hlp_pkg::fifo_status_t fifo_st;
  logic                  accept;
  logic                  pop;

  assign req_stall = (fifo_st.level > hlp_pkg::ACCEPT_LEVEL);
  assign accept    = req_valid && !req_stall;
  assign rsp_valid = !fifo_st.empty;
  assign pop       = rsp_valid && !rsp_stall;

  hlp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .cmd         (cmd),
    .in_byte     (in_byte),
    .batch       (batch)
  );

  hlp_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .batch  (batch),
    .pop    (pop),
    .head   (head),
    .status (fifo_st)
  );

  assign kind        = head.kind;
  assign out_byte    = head.data;
  assign no_prefix   = head.no_prefix;
  assign error_code  = head.code;
  assign last_of_run = head.last;

`ifndef SYNTHESIS
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_st.level <= 3'(hlp_pkg::FIFO_DEPTH))
    else $error("result queue overfilled");

  a_level_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (fifo_st.level ==
      3'($past(fifo_st.level) + 3'($past(batch.count)) - 3'($past(pop)))))
    else $error("result queue level does not follow pushes and pops");

  a_stop_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (kind == hlp_pkg::KIND_ERROR || kind == hlp_pkg::KIND_DONE))
      |-> last_of_run)
    else $error("stopping result is not last of its run");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (fifo_st.empty && !rsp_valid))
    else $error("result queue not empty after reset");
`endif

endmodule
`default_nettype wire

>>> verif/http_header_line_parser_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// http_header_line_parser_unit_test
// Self-checking bench for the HTTP header line parser: a short table of
// directed requests, then random header blocks under several line size
// limits, all checked against a behavioral parser kept in the bench.
// ---------------------------------------------------------------------------
module http_header_line_parser_unit_test;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int PHASE_ITEMS = 28;

  typedef struct {
    logic [1:0]     c;
    logic [7:0]     b;
    bit             typed;
    hlp_pkg::kind_t k;
    hlp_pkg::err_t  e;
  } dir_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [hlp_pkg::LEN_W-1:0]    cfg_wr_data;
  logic                         req_valid;
  logic                         req_stall;
  logic [1:0]                   cmd;
  logic [7:0]                   in_byte;
  logic                         rsp_valid;
  logic                         rsp_stall;
  logic [2:0]                   kind;
  logic [7:0]                   out_byte;
  logic                         no_prefix;
  logic [1:0]                   error_code;
  logic                         last_of_run;

  // expectation attached to a directed request, travels with the payload
  bit                           row_typed;
  hlp_pkg::kind_t               row_kind;
  hlp_pkg::err_t                row_code;

  bit                           calm;
  int                           stall_run;
  int                           errors;
  int                           parsed_cnt;
  int                           n_before;
  hlp_pkg::result_t             want;
  hlp_pkg::result_t             hdr_results [$];
  dir_row_t                     dir_rows [$];

  // parser state mirrored in the bench
  logic [hlp_pkg::LEN_W-1:0]    line_limit;
  hlp_pkg::phase_t              hdr_phase;
  logic [hlp_pkg::LEN_W-1:0]    line_len;
  logic [7:0]                   held_ch;
  bit                           held_ok;
  hlp_pkg::esc_t                pct_state;
  logic [7:0]                   pct_hi;
  logic [3:0]                   match_at;
  logic [1:0]                   match_ok;
  hlp_pkg::kind_t               skip_kind;
  hlp_pkg::err_t                skip_code;

  string                        ct_name = {"CONTENT", "_TYPE"};
  string                        cl_name = {"CONTENT", "_LENGTH"};
  int                           limit_plan [8] = '{65536, 2, 0, 1, 9, 131071, 24, 8192};

  http_header_line_parser_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .cmd         (cmd),
    .in_byte     (in_byte),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .kind        (kind),
    .out_byte    (out_byte),
    .no_prefix   (no_prefix),
    .error_code  (error_code),
    .last_of_run (last_of_run)
  );

  always #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------- header parser model ----------------

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  // strtol(.., 16) over two chars, kept to 8 bits
  function automatic logic [7:0] pct_decode(logic [7:0] hi, logic [7:0] lo);
    int dh;
    int dl;
    dh = hex_digit(hi);
    dl = hex_digit(lo);
    if (dh >= 0) return (dl >= 0) ? 8'(dh * 16 + dl) : 8'(dh);
    if (hi == hlp_pkg::CH_SP || hi == hlp_pkg::CH_TAB || hi == hlp_pkg::CH_LF ||
        hi == hlp_pkg::CH_VT || hi == hlp_pkg::CH_FF || hi == hlp_pkg::CH_CR ||
        hi == hlp_pkg::CH_PLUS) return (dl >= 0) ? 8'(dl) : 8'd0;
    if (hi == hlp_pkg::CH_DASH) return (dl >= 0) ? 8'(256 - dl) : 8'd0;
    return 8'd0;
  endfunction

  task automatic add_result(hlp_pkg::kind_t k, logic [7:0] d, logic np, hlp_pkg::err_t e);
    hlp_pkg::result_t r;
    r.kind      = k;
    r.data      = d;
    r.no_prefix = np;
    r.code      = e;
    r.last      = 1'b0;
    hdr_results.push_back(r);
  endtask

  task automatic start_line();
    hdr_phase = hlp_pkg::PH_NAME;
    line_len  = '0;
    held_ch   = hlp_pkg::CH_NUL;
    held_ok   = 1'b0;
    pct_state = hlp_pkg::ESC_NONE;
    pct_hi    = hlp_pkg::CH_NUL;
    match_at  = '0;
    match_ok  = 2'b11;
    skip_kind = hlp_pkg::KIND_NAME;
    skip_code = hlp_pkg::ERR_EARLY_END;
  endtask

  task automatic release_name_char(logic [7:0] b);
    if (!(match_at < 12 && ct_name[match_at] == b)) match_ok[0] = 1'b0;
    if (!(match_at < 14 && cl_name[match_at] == b)) match_ok[1] = 1'b0;
    if (match_at < 15) match_at = match_at + 4'd1;
    add_result(hlp_pkg::KIND_NAME, b, 1'b0, hlp_pkg::ERR_EARLY_END);
  endtask

  // an unfinished escape goes out literally
  task automatic flush_pct();
    if (pct_state != hlp_pkg::ESC_NONE)
      add_result(hlp_pkg::KIND_VALUE, hlp_pkg::CH_PCT, 1'b0, hlp_pkg::ERR_EARLY_END);
    if (pct_state == hlp_pkg::ESC_FIRST)
      add_result(hlp_pkg::KIND_VALUE, (pct_hi == hlp_pkg::CH_PLUS) ? hlp_pkg::CH_SP : pct_hi,
                 1'b0, hlp_pkg::ERR_EARLY_END);
    pct_state = hlp_pkg::ESC_NONE;
  endtask

  task automatic close_line();
    case (hdr_phase)
      hlp_pkg::PH_NAME: begin
        if (line_len == 0)
          add_result(hlp_pkg::KIND_DONE, hlp_pkg::CH_NUL, 1'b0, hlp_pkg::ERR_EARLY_END);
        else
          add_result(hlp_pkg::KIND_ERROR, hlp_pkg::CH_NUL, 1'b0, hlp_pkg::ERR_NO_SPACE);
        hdr_phase = hlp_pkg::PH_STOP;
      end
      hlp_pkg::PH_VALUE: begin
        flush_pct();
        add_result(hlp_pkg::KIND_HDR_END, hlp_pkg::CH_NUL, 1'b0, hlp_pkg::ERR_EARLY_END);
        start_line();
      end
      hlp_pkg::PH_SKIP: begin
        add_result(skip_kind, hlp_pkg::CH_NUL, 1'b0, skip_code);
        if (skip_kind == hlp_pkg::KIND_HDR_END) start_line();
        else hdr_phase = hlp_pkg::PH_STOP;
      end
      default: ;
    endcase
  endtask

  task automatic take_name_char(logic [7:0] b);
    logic [7:0] t;
    logic       np;
    if (b == hlp_pkg::CH_NUL) begin
      skip_kind = (line_len == 0) ? hlp_pkg::KIND_DONE : hlp_pkg::KIND_ERROR;
      skip_code = (line_len == 0) ? hlp_pkg::ERR_EARLY_END : hlp_pkg::ERR_NO_SPACE;
      hdr_phase = hlp_pkg::PH_SKIP;
    end else if (b == hlp_pkg::CH_SP) begin
      if (!held_ok) begin
        skip_kind = hlp_pkg::KIND_ERROR;
        skip_code = hlp_pkg::ERR_EMPTY_NAME;
        hdr_phase = hlp_pkg::PH_SKIP;
      end else if (held_ch != hlp_pkg::CH_COLON) begin
        skip_kind = hlp_pkg::KIND_ERROR;
        skip_code = hlp_pkg::ERR_NO_COLON;
        hdr_phase = hlp_pkg::PH_SKIP;
      end else begin
        np = (match_ok[0] && match_at == 12) || (match_ok[1] && match_at == 14);
        add_result(hlp_pkg::KIND_NAME_END, hlp_pkg::CH_NUL, np, hlp_pkg::ERR_EARLY_END);
        held_ok   = 1'b0;
        hdr_phase = hlp_pkg::PH_VALUE;
      end
    end else begin
      if (held_ok) release_name_char(held_ch);
      t = b;
      if (t >= "a" && t <= "z") t = t - 8'd32;
      if (t == hlp_pkg::CH_DASH) t = hlp_pkg::CH_US;
      held_ch = t;
      held_ok = 1'b1;
    end
  endtask

  task automatic take_value_char(logic [7:0] b);
    if (b == hlp_pkg::CH_NUL) begin
      flush_pct();
      skip_kind = hlp_pkg::KIND_HDR_END;
      skip_code = hlp_pkg::ERR_EARLY_END;
      hdr_phase = hlp_pkg::PH_SKIP;
    end else if (pct_state == hlp_pkg::ESC_PCT) begin
      pct_hi    = b;
      pct_state = hlp_pkg::ESC_FIRST;
    end else if (pct_state == hlp_pkg::ESC_FIRST) begin
      add_result(hlp_pkg::KIND_VALUE, pct_decode(pct_hi, b), 1'b0, hlp_pkg::ERR_EARLY_END);
      pct_state = hlp_pkg::ESC_NONE;
    end else if (b == hlp_pkg::CH_PCT) begin
      pct_state = hlp_pkg::ESC_PCT;
    end else begin
      add_result(hlp_pkg::KIND_VALUE, (b == hlp_pkg::CH_PLUS) ? hlp_pkg::CH_SP : b, 1'b0,
                 hlp_pkg::ERR_EARLY_END);
    end
  endtask

  task automatic parse_request(logic [1:0] c, logic [7:0] b);
    int  n0;
    bit  at_limit;
    n0 = hdr_results.size();
    if (c == hlp_pkg::CMD_RESTART) begin
      start_line();
    end else if (c != CMD_NOP && hdr_phase != hlp_pkg::PH_STOP) begin
      if (c == hlp_pkg::CMD_EOS) begin
        add_result(hlp_pkg::KIND_ERROR, hlp_pkg::CH_NUL, 1'b0, hlp_pkg::ERR_EARLY_END);
        hdr_phase = hlp_pkg::PH_STOP;
      end else if (b != hlp_pkg::CH_CR) begin
        at_limit = (line_limit != 0) && (line_len >= line_limit - 17'd1);
        if (b == hlp_pkg::CH_LF || at_limit) begin
          close_line();
        end else begin
          if (hdr_phase == hlp_pkg::PH_NAME) take_name_char(b);
          else if (hdr_phase == hlp_pkg::PH_VALUE) take_value_char(b);
          if (line_len < hlp_pkg::LEN_MAX) line_len = line_len + 17'd1;
        end
      end
    end
    if (hdr_results.size() > n0) hdr_results[hdr_results.size() - 1].last = 1'b1;
  endtask

  // ---------------- request tracking and result checking ----------------

  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) begin
      parsed_cnt++;
      n_before = hdr_results.size();
      parse_request(cmd, in_byte);
      if (row_typed) begin
        while (hdr_results.size() > n_before) hdr_results.delete(hdr_results.size() - 1);
        add_result(row_kind, hlp_pkg::CH_NUL, 1'b0, row_code);
        hdr_results[hdr_results.size() - 1].last = 1'b1;
      end
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (hdr_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d byte %02h np %0b code %0d last %0b",
                 $time, kind, out_byte, no_prefix, error_code, last_of_run);
        errors++;
      end else begin
        want = hdr_results.pop_front();
        if (kind !== want.kind || out_byte !== want.data || no_prefix !== want.no_prefix ||
            error_code !== want.code || last_of_run !== want.last) begin
          $display("%0t: expected kind %0d byte %02h np %0b code %0d last %0b", $time,
                   want.kind, want.data, want.no_prefix, want.code, want.last);
          $display("%0t:   actual kind %0d byte %02h np %0b code %0d last %0b", $time,
                   kind, out_byte, no_prefix, error_code, last_of_run);
          errors++;
        end
      end
    end
  end

  // result side back-pressure in bursts
  always @(negedge clk) begin
    if (rst || calm) begin
      rsp_stall <= 1'b0;
      stall_run = 0;
    end else if (stall_run > 0) begin
      rsp_stall <= 1'b1;
      stall_run--;
    end else if ($urandom_range(0, 5) == 0) begin
      rsp_stall <= 1'b1;
      stall_run = $urandom_range(0, 9);
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // ---------------- stimulus ----------------

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_request(logic [1:0] c, logic [7:0] b, bit typed, hlp_pkg::kind_t k,
                              hlp_pkg::err_t e);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    req_valid <= 1'b1;
    cmd       <= c;
    in_byte   <= b;
    row_typed <= typed;
    row_kind  <= k;
    row_code  <= e;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_plain(logic [1:0] c, logic [7:0] b);
    send_request(c, b, 1'b0, hlp_pkg::KIND_NAME, hlp_pkg::ERR_EARLY_END);
  endtask

  // header byte with an occasional stray command or corrupted byte
  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(0, 49) == 0) send_plain(CMD_NOP, 8'($urandom));
    if ($urandom_range(0, 39) == 0) b = 8'($urandom);
    send_plain(hlp_pkg::CMD_DATA, b);
  endtask

  function automatic logic [7:0] rand_name_char();
    case ($urandom_range(0, 9))
      0:       return hlp_pkg::CH_DASH;
      1:       return 8'($urandom_range(48, 57));
      2, 3, 4: return 8'($urandom_range(65, 90));
      9:       return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  function automatic logic [7:0] rand_pct_char();
    case ($urandom_range(0, 11))
      0:       return hlp_pkg::CH_SP;
      1:       return hlp_pkg::CH_PLUS;
      2:       return hlp_pkg::CH_DASH;
      3:       return hlp_pkg::CH_TAB;
      4:       return ($urandom_range(0, 1) != 0) ? hlp_pkg::CH_VT : hlp_pkg::CH_FF;
      5:       return 8'($urandom_range(1, 255));
      6, 7:    return 8'($urandom_range(48, 57));
      8:       return 8'($urandom_range(97, 102));
      9:       return 8'($urandom_range(65, 70));
      default: return 8'($urandom_range(71, 90));
    endcase
  endfunction

  task automatic send_name();
    string s;
    int    i;
    case ($urandom_range(0, 9))
      0:       s = "content-type";
      1:       s = {"CONTENT", "_LENGTH"};
      2:       s = "Content-Length";
      3:       s = "CONTENT-TYPEX";
      4:       s = "content-lengt";
      default: s = "";
    endcase
    if (s.len() != 0) begin
      for (i = 0; i < s.len(); i++) send_byte(s[i]);
    end else begin
      repeat ($urandom_range(1, 18)) send_byte(rand_name_char());
    end
  endtask

  task automatic send_value();
    int r;
    repeat ($urandom_range(0, 12)) begin
      r = $urandom_range(0, 19);
      if (r < 3) begin
        send_byte(hlp_pkg::CH_PCT);
        // escapes cut short by line end come out literally
        if ($urandom_range(0, 5) != 0) send_byte(rand_pct_char());
        if ($urandom_range(0, 5) != 0) send_byte(rand_pct_char());
      end else if (r < 5) begin
        send_byte(hlp_pkg::CH_PLUS);
      end else if (r == 5) begin
        send_byte(hlp_pkg::CH_CR);
      end else if (r == 6) begin
        send_byte(8'($urandom));
      end else begin
        send_byte(8'($urandom_range(33, 126)));
      end
    end
  endtask

  task automatic send_header_line();
    int form;
    form = $urandom_range(0, 13);
    if (form != 1) send_name();
    if (form == 5) send_byte(hlp_pkg::CH_NUL);
    if (form != 2) send_byte(hlp_pkg::CH_COLON);
    if (form != 3) begin
      send_byte(hlp_pkg::CH_SP);
      send_value();
    end
    if (form == 4) begin
      send_byte(hlp_pkg::CH_NUL);
      send_value();
    end
    if ($urandom_range(0, 1) != 0) send_byte(hlp_pkg::CH_CR);
    send_byte(hlp_pkg::CH_LF);
  endtask

  task automatic send_header_block();
    send_plain(hlp_pkg::CMD_RESTART, 8'($urandom));
    repeat ($urandom_range(0, 3)) send_header_line();
    case ($urandom_range(0, 9))
      0: send_plain(hlp_pkg::CMD_EOS, 8'($urandom));
      1: begin
        send_byte(hlp_pkg::CH_NUL);
        send_byte(hlp_pkg::CH_LF);
      end
      default: begin
        if ($urandom_range(0, 1) != 0) send_byte(hlp_pkg::CH_CR);
        send_byte(hlp_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    while (hdr_results.size() != 0) @(posedge clk);
    // a request with no result may still be in flight
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_limit(logic [hlp_pkg::LEN_W-1:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    line_limit = v;
  endtask

  task automatic dir_row(logic [1:0] c, logic [7:0] b, bit typed, hlp_pkg::kind_t k,
                         hlp_pkg::err_t e);
    dir_row_t r;
    r.c     = c;
    r.b     = b;
    r.typed = typed;
    r.k     = k;
    r.e     = e;
    dir_rows.push_back(r);
  endtask

  initial begin
    int p;
    int base;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    req_valid   = 1'b0;
    cmd         = hlp_pkg::CMD_DATA;
    in_byte     = hlp_pkg::CH_NUL;
    rsp_stall   = 1'b0;
    row_typed   = 1'b0;
    row_kind    = hlp_pkg::KIND_NAME;
    row_code    = hlp_pkg::ERR_EARLY_END;
    calm        = 1'b0;
    errors      = 0;
    parsed_cnt  = 0;
    line_limit  = hlp_pkg::LIMIT_RESET;
    start_line();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: error codes, empty line, one well-formed header with escapes
    dir_row(hlp_pkg::CMD_EOS,     hlp_pkg::CH_NUL,   1, hlp_pkg::KIND_ERROR,
            hlp_pkg::ERR_EARLY_END);
    dir_row(CMD_NOP,              8'hFF,             0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_RESTART, 8'hA5,             0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_LF,    1, hlp_pkg::KIND_DONE,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_RESTART, hlp_pkg::CH_NUL,   0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_SP,    0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_LF,    1, hlp_pkg::KIND_ERROR,
            hlp_pkg::ERR_EMPTY_NAME);
    dir_row(hlp_pkg::CMD_RESTART, hlp_pkg::CH_NUL,   0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    "a",               0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_SP,    0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_LF,    1, hlp_pkg::KIND_ERROR,
            hlp_pkg::ERR_NO_COLON);
    dir_row(hlp_pkg::CMD_RESTART, hlp_pkg::CH_NUL,   0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    "b",               0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_LF,    1, hlp_pkg::KIND_ERROR,
            hlp_pkg::ERR_NO_SPACE);
    dir_row(hlp_pkg::CMD_RESTART, hlp_pkg::CH_NUL,   0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_DASH,  0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_COLON, 0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_SP,    0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_PCT,   0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    "4",               0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    "1",               0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_PLUS,  0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_CR,    0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    8'hFF,             0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    dir_row(hlp_pkg::CMD_DATA,    hlp_pkg::CH_LF,    0, hlp_pkg::KIND_NAME,
            hlp_pkg::ERR_EARLY_END);
    foreach (dir_rows[i])
      send_request(dir_rows[i].c, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].k,
                   dir_rows[i].e);

    // random header blocks, one limit per phase; the last phase runs at full rate
    base = parsed_cnt;
    for (p = 0; p < 8; p++) begin
      set_limit(hlp_pkg::LEN_W'(limit_plan[p]));
      calm = (p == 7) || ($urandom_range(0, 3) == 0);
      while (parsed_cnt < base + (p + 1) * PHASE_ITEMS) send_header_block();
    end

    wait_idle();
    if (errors == 0 && hdr_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
